// ----- design/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: request and
// result payloads, request codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  // Default sizes (WORD_BITS must be a power of two)
  localparam int DEF_MAX_FRAMES = 4096;
  localparam int DEF_WORD_BITS  = 32;

  // Fixed field widths
  localparam int CFG_W   = 13;
  localparam int FRAME_W = 12;

  // Managed frame count after reset
  localparam logic [CFG_W-1:0] FRAMES_RESET = 13'd4096;

  // Words per group in the first level of the free-word search
  localparam int SRCH_GRP = 16;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FRAME_W-1:0] frame_index;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               rw_page;
  } alloc_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               present;
    logic               writable;
    logic               user_access;
    logic               newly_allocated;
    logic               full_res;
    logic               bit_was_set;
  } alloc_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_READ,
    ST_MODIFY
  } state_t;

endpackage

`default_nettype wire

// ----- design/bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit allocator of physical page frames over a used/free bitmap held in
// one synchronous RAM, with a per-word full vector to locate free words.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// is registered onto res as done goes high for exactly one cycle, and cannot
// be held off. An allocate that needs a new frame passes the accept cycle,
// search level one, search level two with the RAM read, then modify and
// write back, or ends after search level two when the bitmap is full; a free
// or test of a stored frame passes the accept cycle, RAM read, then modify;
// every other request ends in its accept cycle. Words never written since
// reset read as zero through per-word valid flags, so the bitmap needs no
// clearing pass. The user must write frames_in_use through cfg_we/cfg_wdata
// only while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator_top #(
  parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES,
  parameter int WORD_BITS  = bfa_pkg::DEF_WORD_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire bfa_pkg::alloc_req_t        req,
  output logic                            done,
  output bfa_pkg::alloc_res_t             res,
  input  wire logic                       cfg_we,
  input  wire logic [bfa_pkg::CFG_W-1:0]  cfg_wdata
);

  import bfa_pkg::*;

  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WB_SH  = $clog2(WORD_BITS);
  localparam int F_W    = WIDX_W + WB_SH;
  localparam int LIM_W  = (CFG_W > $clog2(MAX_FRAMES + 1)) ? CFG_W : $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = LIM_W + F_W;

  // Control and configuration registers
  state_t              state;
  state_t              state_next;
  logic [CFG_W-1:0]    frames_in_use;
  logic [NWORDS-1:0]   full_flags;
  logic [NWORDS-1:0]   valid;
  logic                done_next;

  // Payload registers
  alloc_req_t          rq;
  logic [WIDX_W-1:0]   cur_word;
  logic [WB_SH-1:0]    cur_bit;
  alloc_res_t          res_next;

  // Combinational signals
  logic [LIM_W-1:0]    lim;
  logic [LIM_W-1:0]    sel_frame;
  logic                sel_in_store;
  logic                accept;
  logic                srch_found;
  logic [WIDX_W-1:0]   srch_word;
  logic                srch_step;
  logic                mem_re;
  logic [WIDX_W-1:0]   mem_raddr;
  logic                mem_we;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [WORD_BITS-1:0] cur_data;
  logic [WB_SH-1:0]    zero_bit;
  logic                zero_any;
  logic [F_W-1:0]      new_frame;
  logic                alloc_ok;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Effective search limit: the managed count, capped at storage
  assign lim = (LIM_W'(frames_in_use) > LIM_W'(MAX_FRAMES)) ?
               LIM_W'(MAX_FRAMES) : LIM_W'(frames_in_use);

  // Frame addressed by a free or test request
  assign sel_frame    = (req.req_type == REQ_TEST) ? LIM_W'(req.frame_index)
                                                   : LIM_W'(req.current_frame);
  assign sel_in_store = (sel_frame < LIM_W'(MAX_FRAMES));

  // Bitmap word as stored, zero if never written
  assign cur_data = valid[cur_word] ? mem_rdata : '0;

  // Lowest free bit of the word under modification
  always_comb begin
    zero_bit = '0;
    zero_any = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!cur_data[i]) begin
        zero_bit = WB_SH'(i);
        zero_any = 1'b1;
      end
    end
  end

  assign new_frame = {cur_word, zero_bit};
  assign alloc_ok  = zero_any && (CMP_W'(new_frame) < CMP_W'(lim));

  bfa_search #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_search (
    .clk   (clk),
    .step  (srch_step),
    .full  (full_flags),
    .lim   (lim),
    .found (srch_found),
    .word  (srch_word)
  );

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_word),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_ALLOC: begin
              if (req.current_frame == '0) begin
                state_next = ST_SCAN;
              end
            end
            REQ_FREE: begin
              if ((req.current_frame != '0) && sel_in_store) begin
                state_next = ST_READ;
              end
            end
            REQ_TEST: begin
              if (sel_in_store) begin
                state_next = ST_READ;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: state_next = ST_PICK;
      ST_PICK: begin
        state_next = srch_found ? ST_MODIFY : ST_IDLE;
      end
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: RAM access, write-back data and result
  always_comb begin
    srch_step = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cur_word;
    mem_we    = 1'b0;
    mem_wdata = cur_data;
    res_next  = '0;
    done_next = 1'b0;
    case (state)
      ST_IDLE: begin
        // Requests that need no bitmap access finish at once
        if (accept && (state_next == ST_IDLE)) begin
          done_next = 1'b1;
          if (req.req_type == REQ_ALLOC) begin
            res_next.frame_out = req.current_frame;
          end
        end
      end
      ST_SCAN: begin
        srch_step = 1'b1;
      end
      ST_PICK: begin
        if (srch_found) begin
          mem_re    = 1'b1;
          mem_raddr = srch_word;
        end else begin
          res_next.full_res = 1'b1;
          done_next         = 1'b1;
        end
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_MODIFY: begin
        done_next = 1'b1;
        case (rq.req_type)
          REQ_ALLOC: begin
            if (alloc_ok) begin
              mem_we                   = 1'b1;
              mem_wdata                = cur_data | (WORD_BITS'(1) << zero_bit);
              res_next.frame_out       = FRAME_W'(new_frame);
              res_next.present         = 1'b1;
              res_next.writable        = rq.rw_page;
              res_next.user_access     = !rq.kernel_page;
              res_next.newly_allocated = 1'b1;
            end else begin
              res_next.full_res = 1'b1;
            end
          end
          REQ_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = cur_data & ~(WORD_BITS'(1) << cur_bit);
          end
          REQ_TEST: begin
            res_next.bit_was_set = cur_data[cur_bit];
          end
          default: done_next = 1'b1;
        endcase
      end
      default: done_next = 1'b0;
    endcase
  end

  // Hold state, done, configuration, full and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= FRAMES_RESET;
      full_flags    <= '0;
      valid         <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      if (mem_we) begin
        valid[cur_word]      <= 1'b1;
        full_flags[cur_word] <= &mem_wdata;
      end
    end
  end

  // Latch the request and its word address; publish the result
  always_ff @(posedge clk) begin
    if (accept) begin
      rq       <= req;
      cur_word <= WIDX_W'(sel_frame >> WB_SH);
      cur_bit  <= WB_SH'(sel_frame);
    end else if ((state == ST_PICK) && srch_found) begin
      cur_word <= srch_word;
    end
    if (done_next) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bfa_search.sv -----
// ----------------------------------------------------------------------------
// bfa_search
// Two-level search for the lowest bitmap word that is not full and lies below
// the frame limit. Level one finds the first eligible word of each group and
// is registered; level two picks the first group that has one.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_search #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic step,
  input  wire logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS)-1:0] full,
  input  wire logic [((bfa_pkg::CFG_W > $clog2(MAX_FRAMES + 1)) ?
                      bfa_pkg::CFG_W : $clog2(MAX_FRAMES + 1))-1:0] lim,
  output logic      found,
  output logic [(((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) > 1 ?
                 $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] word
);

  import bfa_pkg::*;

  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WB_SH  = $clog2(WORD_BITS);
  localparam int LIM_W  = (CFG_W > $clog2(MAX_FRAMES + 1)) ? CFG_W : $clog2(MAX_FRAMES + 1);
  localparam int GRP_W  = $clog2(SRCH_GRP);
  localparam int NGRP   = (NWORDS + SRCH_GRP - 1) / SRCH_GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic [LIM_W:0]             lim_words;
  logic [NGRP*SRCH_GRP-1:0]   elig;
  logic [NGRP-1:0]            grp_any_next;
  logic [GRP_W-1:0]           grp_idx_next [NGRP];
  logic [NGRP-1:0]            grp_any;
  logic [GRP_W-1:0]           grp_idx [NGRP];
  logic [NGRP_W-1:0]          gsel;
  logic                       gany;

  // Words whose first frame lies below the limit
  assign lim_words = ((LIM_W + 1)'(lim) + (LIM_W + 1)'(WORD_BITS - 1)) >> WB_SH;

  // Mark words that are below the limit and still have a free bit
  always_comb begin
    elig = '0;
    for (int i = 0; i < NWORDS; i++) begin
      elig[i] = !full[i] && ((LIM_W + 1)'(i) < lim_words);
    end
  end

  // Level one: first eligible word inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int j = SRCH_GRP - 1; j >= 0; j--) begin
        if (elig[g*SRCH_GRP + j]) begin
          grp_any_next[g] = 1'b1;
          grp_idx_next[g] = GRP_W'(j);
        end
      end
    end
  end

  // Hold level-one results for the pick cycle
  always_ff @(posedge clk) begin
    if (step) begin
      grp_any <= grp_any_next;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx[g] <= grp_idx_next[g];
      end
    end
  end

  // Level two: first group with an eligible word
  always_comb begin
    gsel = '0;
    gany = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = NGRP_W'(g);
        gany = 1'b1;
      end
    end
  end

  assign found = gany;
  assign word  = WIDX_W'({gsel, grp_idx[gsel]});

endmodule

`default_nettype wire
